### sv/plwg_pkg.sv
// Shared types, constants and tables of the polar line waypoint generator.
`timescale 1ns / 1ps

package plwg_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_REACH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REACH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SHIFT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_Q8    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN     = 3'd6;

	// waypoint count, wide enough for the largest cap
	localparam int WP_W = 7;

	// shared serial divider
	localparam int DIV_W = 21;
	localparam int DVS_W = 8;

	// CORDIC datapath
	localparam int CW       = 26;
	localparam int ACC_W    = 32;
	localparam int ATAN_LEN = 24;
	localparam logic signed [ACC_W-1:0] ACC_90 = 32'sd377487360;
	localparam logic [16:0] GAIN_Q16 = 17'd39797;

	// servo mapping: pulse = 500 + a * 25 / 216, a clamped to 0..17280
	// 25 / 216 in Q20, rounded up; exact after truncation over that range
	localparam logic [14:0] SERVO_SPAN  = 15'd17280;
	localparam logic [11:0] PULSE_MIN   = 12'd500;
	localparam logic [16:0] SERVO_RECIP = 17'd121363;

	typedef struct packed {
		logic [11:0]        pivot_x;
		logic [11:0]        pivot_y;
		logic [11:0]        min_reach;
		logic [12:0]        max_reach;
		logic signed [14:0] angle_shift;
		logic [15:0]        steps_q8;
		logic [11:0]        seg_len;
	} cfg_t;

	typedef struct packed {
		logic signed [12:0] px;
		logic signed [12:0] py;
		logic signed [13:0] dx;
		logic signed [13:0] dy;
		logic [WP_W-1:0]    n;
	} move_t;

	typedef struct packed {
		logic [11:0]        servo_pulse_us;
		logic [14:0]        stepper_target;
		logic signed [15:0] step_delta;
		logic [3:0]         coil_pattern;
		logic               last_waypoint;
	} result_t;

	// arctangent of 2^-k in degree * 2^22
	function automatic logic signed [ACC_W-1:0] atan_entry(input logic [4:0] k);
		logic signed [ACC_W-1:0] v;
		case (k)
			5'd0:    v = 32'sd188743680;
			5'd1:    v = 32'sd111421900;
			5'd2:    v = 32'sd58872272;
			5'd3:    v = 32'sd29884485;
			5'd4:    v = 32'sd15000234;
			5'd5:    v = 32'sd7507429;
			5'd6:    v = 32'sd3754631;
			5'd7:    v = 32'sd1877430;
			5'd8:    v = 32'sd938729;
			5'd9:    v = 32'sd469366;
			5'd10:   v = 32'sd234683;
			5'd11:   v = 32'sd117342;
			5'd12:   v = 32'sd58671;
			5'd13:   v = 32'sd29335;
			5'd14:   v = 32'sd14668;
			5'd15:   v = 32'sd7334;
			5'd16:   v = 32'sd3667;
			5'd17:   v = 32'sd1833;
			5'd18:   v = 32'sd917;
			5'd19:   v = 32'sd458;
			5'd20:   v = 32'sd229;
			5'd21:   v = 32'sd115;
			5'd22:   v = 32'sd57;
			5'd23:   v = 32'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

	// full-step coil drive for each phase
	function automatic logic [3:0] coil_of(input logic [1:0] phase);
		logic [3:0] c;
		case (phase)
			2'd0:    c = 4'h3;
			2'd1:    c = 4'h6;
			2'd2:    c = 4'hC;
			2'd3:    c = 4'h9;
			default: c = 4'h3;
		endcase
		return c;
	endfunction

endpackage

### sv/polar_line_waypoint_generator.sv
// Top level of the polar line waypoint generator: configuration, queues and stages.
`timescale 1ns / 1ps
// A move passes through the front after its transfer (two squares, a root, a count to n, the hand-over)
// and then through the move queue before its first waypoint starts.
// Each waypoint takes two passes through the shared serial divider and the CORDIC loop, one
// waypoint at a time; the back end stalls while the result queue is full.
// Reset (arst_n low, asynchronous): registers to their defaults, position to the home point,
// step position and coil phase to zero, all queues empty.

module polar_line_waypoint_generator #(
	parameter int MAX_WAYPOINTS = 64,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            wr_en,
	input  logic [plwg_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [plwg_pkg::CFG_DATA_W-1:0] wr_data,
	// target side
	input  logic                            push,
	output logic                            full,
	input  logic signed [12:0]              target_x,
	input  logic signed [12:0]              target_y,
	// waypoint side
	output logic                            empty,
	input  logic                            pop,
	output logic [11:0]                     servo_pulse_us,
	output logic [14:0]                     stepper_target,
	output logic signed [15:0]              step_delta,
	output logic [3:0]                      coil_pattern,
	output logic                            last_waypoint
);
	import plwg_pkg::*;

	cfg_t    cfg_q;
	move_t   mv_in, mv_out;
	result_t res_in, res_out;
	logic    mv_push, mv_full, mv_pop, mv_empty;
	logic    res_push, res_full;

	// Register file: take a write at once, ignore indexes beyond the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pivot_x     <= 12'd160;
			cfg_q.pivot_y     <= 12'd1984;
			cfg_q.min_reach   <= 12'd768;
			cfg_q.max_reach   <= 13'd3200;
			cfg_q.angle_shift <= 15'sd3072;
			cfg_q.steps_q8    <= 16'd14486;
			cfg_q.seg_len     <= 12'd80;
		end else if (wr_en) begin
			case (wr_index)
				REG_PIVOT_X:     cfg_q.pivot_x     <= wr_data[11:0];
				REG_PIVOT_Y:     cfg_q.pivot_y     <= wr_data[11:0];
				REG_MIN_REACH:   cfg_q.min_reach   <= wr_data[11:0];
				REG_MAX_REACH:   cfg_q.max_reach   <= wr_data[12:0];
				REG_ANGLE_SHIFT: cfg_q.angle_shift <= wr_data[14:0];
				REG_STEPS_Q8:    cfg_q.steps_q8    <= wr_data;
				REG_SEG_LEN:     cfg_q.seg_len     <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	// Front: accept a target, measure the move, hand over a move descriptor.
	plwg_front #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.target_x (target_x),
		.target_y (target_y),
		.cfg      (cfg_q),
		.mv_push  (mv_push),
		.mv_full  (mv_full),
		.mv       (mv_in)
	);

	// Move queue: let the front take the next target while the back still walks a line.
	plwg_fifo #(
		.WIDTH ($bits(move_t)),
		.DEPTH (2)
	) u_move_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mv_push),
		.din    (mv_in),
		.full   (mv_full),
		.pop    (mv_pop),
		.dout   (mv_out),
		.empty  (mv_empty)
	);

	// Back: one waypoint at a time through division, CORDIC and drive mapping.
	plwg_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mv_empty (mv_empty),
		.mv_pop   (mv_pop),
		.mv       (mv_out),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// Result queue: hold finished waypoints until the consumer takes the transfer.
	plwg_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (4)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign servo_pulse_us = res_out.servo_pulse_us;
	assign stepper_target = res_out.stepper_target;
	assign step_delta     = res_out.step_delta;
	assign coil_pattern   = res_out.coil_pattern;
	assign last_waypoint  = res_out.last_waypoint;

endmodule

### sv/plwg_fifo.sv
// Small register queue used between the stages and on the result side.
`timescale 1ns / 1ps

module plwg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

### sv/plwg_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module plwg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [plwg_pkg::DIV_W-1:0] dividend,
	input  logic [plwg_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [plwg_pkg::DIV_W-1:0] quot,
	output logic                       rem_nz
);
	import plwg_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DVS_W:0]   shifted, trial;
	logic             ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign done   = done_q;
	assign quot   = quo_q;
	assign rem_nz = |rem_q;

endmodule

### sv/plwg_front.sv
// Front end: accepts targets, measures the move and sets its waypoint count.
`timescale 1ns / 1ps

module plwg_front #(
	parameter int MAX_WAYPOINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [12:0]  target_x,
	input  logic signed [12:0]  target_y,
	input  plwg_pkg::cfg_t      cfg,
	output logic                mv_push,
	input  logic                mv_full,
	output plwg_pkg::move_t     mv
);
	import plwg_pkg::*;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_SQX   = 3'd1;
	localparam logic [2:0] F_SQY   = 3'd2;
	localparam logic [2:0] F_ROOT  = 3'd3;
	localparam logic [2:0] F_COUNT = 3'd4;
	localparam logic [2:0] F_PUSH  = 3'd5;

	logic [2:0]         state_q;
	logic signed [12:0] pos_x_q, pos_y_q, px_q, py_q;
	logic signed [13:0] dx_q, dy_q;
	logic [27:0]        d2_q, rem_q, root_q, bit_q;
	logic [3:0]         cnt_q;
	logic [13:0]        len_q;
	logic [18:0]        acc_q;
	logic [WP_W-1:0]    k_q;

	logic               take;
	logic [13:0]        dx_new, dy_new;
	logic signed [27:0] sqx, sqy;
	logic [27:0]        trial, rem_n, root_n;
	logic               ge;
	logic [11:0]        seg_eff;
	logic               count_done;

	assign take   = push && !full;
	assign dx_new = {target_x[12], target_x} - {pos_x_q[12], pos_x_q};
	assign dy_new = {target_y[12], target_y} - {pos_y_q[12], pos_y_q};
	assign sqx    = dx_q * dx_q;
	assign sqy    = dy_q * dy_q;

	// one result bit of the integer square root per cycle
	assign trial  = root_q + bit_q;
	assign ge     = (rem_q >= trial);
	assign rem_n  = ge ? rem_q - trial : rem_q;
	assign root_n = ge ? (root_q >> 1) + bit_q : (root_q >> 1);

	assign seg_eff    = (cfg.seg_len == '0) ? 12'd1 : cfg.seg_len;
	assign count_done = (acc_q >= {5'b0, len_q}) || (k_q == WP_W'(MAX_WAYPOINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pos_x_q <= -13'sd160;
			pos_y_q <= -13'sd1216;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						pos_x_q <= target_x;
						pos_y_q <= target_y;
						if (dx_new != '0 || dy_new != '0)
							state_q <= F_SQX;
					end
				end
				F_SQX: state_q <= F_SQY;
				F_SQY: begin
					cnt_q   <= 4'd13;
					state_q <= F_ROOT;
				end
				F_ROOT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						k_q     <= WP_W'(1);
						state_q <= F_COUNT;
					end
				end
				F_COUNT: begin
					if (count_done)
						state_q <= F_PUSH;
					else
						k_q <= k_q + 1'b1;
				end
				F_PUSH: begin
					if (!mv_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				px_q <= pos_x_q;
				py_q <= pos_y_q;
				dx_q <= dx_new;
				dy_q <= dy_new;
			end
			F_SQX: d2_q <= sqx;
			F_SQY: begin
				rem_q  <= d2_q + sqy;
				root_q <= '0;
				bit_q  <= 28'h400_0000;
			end
			F_ROOT: begin
				rem_q  <= rem_n;
				root_q <= root_n;
				bit_q  <= bit_q >> 2;
				if (cnt_q == '0) begin
					// round the length up where the root is not exact
					len_q <= root_n[13:0] + {13'b0, (rem_n != '0)};
					acc_q <= {7'b0, seg_eff};
				end
			end
			F_COUNT: acc_q <= acc_q + {7'b0, seg_eff};
			default: ;
		endcase
	end

	assign full       = (state_q != F_IDLE);
	assign mv_push    = (state_q == F_PUSH);
	assign mv.px      = px_q;
	assign mv.py      = py_q;
	assign mv.dx      = dx_q;
	assign mv.dy      = dy_q;
	assign mv.n       = k_q;

endmodule

### sv/plwg_back.sv
// Back end: walks the waypoints of a move through division, CORDIC and drive mapping.
`timescale 1ns / 1ps

module plwg_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  plwg_pkg::cfg_t    cfg,
	input  logic              mv_empty,
	output logic              mv_pop,
	input  plwg_pkg::move_t   mv,
	input  logic              res_full,
	output logic              res_push,
	output plwg_pkg::result_t res
);
	import plwg_pkg::*;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_XL   = 4'd1;
	localparam logic [3:0] B_XW   = 4'd2;
	localparam logic [3:0] B_YL   = 4'd3;
	localparam logic [3:0] B_YW   = 4'd4;
	localparam logic [3:0] B_CI   = 4'd5;
	localparam logic [3:0] B_CR   = 4'd6;
	localparam logic [3:0] B_RM   = 4'd7;
	localparam logic [3:0] B_AN   = 4'd8;
	localparam logic [3:0] B_SL   = 4'd9;
	localparam logic [3:0] B_SM   = 4'd11;
	localparam logic [3:0] B_OUT  = 4'd12;

	function automatic logic [15:0] floor_add(input logic [12:0] base, input logic neg,
			input logic [DIV_W-1:0] q, input logic nz);
		logic [15:0] mag;
		logic [15:0] off;
		mag = q[15:0] + {15'b0, (neg & nz)};
		off = neg ? (16'd0 - mag) : mag;
		return {{3{base[12]}}, base} + off;
	endfunction

	logic [3:0]               state_q;
	logic [WP_W-1:0]          i_q;
	logic [4:0]               k_q;
	logic [1:0]               phase_q;
	logic [14:0]              step_pos_q;
	move_t                    mv_q;
	logic [21:0]              numx_q, numy_q;
	logic [15:0]              wx_q, wy_q;
	logic signed [CW-1:0]     x_q, y_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     zero_q;
	logic [23:0]              rad_q;
	logic [14:0]              a_q;
	logic [20:0]              ext_q;
	logic [11:0]              servo_q;
	logic [14:0]              tgt_q;

	logic                     div_start, div_done, div_nz;
	logic [DIV_W-1:0]         div_dividend, div_quot;
	logic [DVS_W-1:0]         div_divisor;

	logic [21:0]              two_dx, two_dy;
	logic [15:0]              rx, ry;
	logic signed [CW-1:0]     x0, y0, xs, ys;
	logic signed [42:0]       rprod;
	logic [42:0]              rsum;
	logic [ACC_W-1:0]         angsum;
	logic [16:0]              a17;
	logic [24:0]              e25;
	logic [20:0]              span;
	logic [36:0]              sprod;
	logic [16:0]              t17;
	logic [31:0]              smul;
	logic [15:0]              delta;
	logic [1:0]               phase_n;

	assign two_dx = {{7{mv_q.dx[13]}}, mv_q.dx, 1'b0};
	assign two_dy = {{7{mv_q.dy[13]}}, mv_q.dy, 1'b0};

	// one divider serves both coordinates
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = {mv_q.n, 1'b0};
		case (state_q)
			B_XL: begin
				div_start    = 1'b1;
				div_dividend = numx_q[21] ? 21'(22'd0 - numx_q) : numx_q[20:0];
			end
			B_YL: begin
				div_start    = 1'b1;
				div_dividend = numy_q[21] ? 21'(22'd0 - numy_q) : numy_q[20:0];
			end
			default: ;
		endcase
	end

	plwg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem_nz   (div_nz)
	);

	// waypoint relative to the pivot, scaled by 256
	assign rx = wx_q + {4'b0, cfg.pivot_x};
	assign ry = wy_q + {4'b0, cfg.pivot_y};
	assign x0 = {{2{rx[15]}}, rx, 8'b0};
	assign y0 = {{2{ry[15]}}, ry, 8'b0};
	assign xs = x_q >>> k_q;
	assign ys = y_q >>> k_q;

	assign rprod  = x_q * $signed({1'b0, GAIN_Q16[15:0]});
	assign rsum   = rprod + 43'sd32768;
	assign angsum = acc_q + 32'sd32768;
	assign a17    = (zero_q ? 17'd0 : {angsum[31], angsum[31:16]})
		+ {{2{cfg.angle_shift[14]}}, cfg.angle_shift};
	assign e25    = {rad_q[23], rad_q} - {5'b0, cfg.min_reach, 8'b0};
	assign span   = (cfg.max_reach > {1'b0, cfg.min_reach})
		? {(cfg.max_reach - {1'b0, cfg.min_reach}), 8'b0} : 21'd0;
	assign sprod  = {16'b0, ext_q} * {21'b0, cfg.steps_q8};
	assign t17    = sprod[36:20];
	assign smul   = {17'b0, a_q} * {15'b0, SERVO_RECIP};
	assign delta  = {1'b0, tgt_q} - {1'b0, step_pos_q};
	assign phase_n = phase_q + delta[1:0];

	assign mv_pop   = (state_q == B_IDLE) && !mv_empty;
	assign res_push = (state_q == B_OUT) && !res_full;

	assign res.servo_pulse_us = servo_q;
	assign res.stepper_target = tgt_q;
	assign res.step_delta     = delta;
	assign res.coil_pattern   = coil_of(phase_n);
	assign res.last_waypoint  = (i_q == mv_q.n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			i_q        <= '0;
			k_q        <= '0;
			phase_q    <= '0;
			step_pos_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (mv_pop) begin
						i_q     <= WP_W'(1);
						state_q <= B_XL;
					end
				end
				B_XL: state_q <= B_XW;
				B_XW: if (div_done) state_q <= B_YL;
				B_YL: state_q <= B_YW;
				B_YW: if (div_done) state_q <= B_CI;
				B_CI: begin
					k_q     <= '0;
					state_q <= B_CR;
				end
				B_CR: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'(CORDIC_STEPS - 1))
						state_q <= B_RM;
				end
				B_RM: state_q <= B_AN;
				B_AN: state_q <= B_SL;
				B_SL: state_q <= B_SM;
				B_SM: state_q <= B_OUT;
				B_OUT: begin
					if (res_push) begin
						step_pos_q <= tgt_q;
						phase_q    <= phase_n;
						if (i_q == mv_q.n) begin
							state_q <= B_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= B_XL;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				mv_q   <= mv;
				numx_q <= {{7{mv.dx[13]}}, mv.dx, 1'b0} + {15'b0, mv.n};
				numy_q <= {{7{mv.dy[13]}}, mv.dy, 1'b0} + {15'b0, mv.n};
			end
			B_XW: if (div_done) wx_q <= floor_add(mv_q.px, numx_q[21], div_quot, div_nz);
			B_YW: if (div_done) wy_q <= floor_add(mv_q.py, numy_q[21], div_quot, div_nz);
			B_CI: begin
				zero_q <= (rx == '0) && (ry == '0);
				// turn the left half plane by a quarter turn first
				if (x0 < 0) begin
					if (y0 >= 0) begin
						x_q   <= y0;
						y_q   <= -x0;
						acc_q <= ACC_90;
					end else begin
						x_q   <= -y0;
						y_q   <= x0;
						acc_q <= -ACC_90;
					end
				end else begin
					x_q   <= x0;
					y_q   <= y0;
					acc_q <= '0;
				end
			end
			B_CR: begin
				if (y_q >= 0) begin
					x_q   <= x_q + ys;
					y_q   <= y_q - xs;
					acc_q <= acc_q + atan_entry(k_q);
				end else begin
					x_q   <= x_q - ys;
					y_q   <= y_q + xs;
					acc_q <= acc_q - atan_entry(k_q);
				end
			end
			B_RM: rad_q <= rsum[39:16];
			B_AN: begin
				if (a17[16])
					a_q <= '0;
				else if (a17[15:0] > {1'b0, SERVO_SPAN})
					a_q <= SERVO_SPAN;
				else
					a_q <= a17[14:0];
				if (e25[24])
					ext_q <= '0;
				else if (e25[23:0] > {3'b0, span})
					ext_q <= span;
				else
					ext_q <= e25[20:0];
			end
			B_SL: servo_q <= PULSE_MIN + smul[31:20];
			B_SM: tgt_q <= (t17 > 17'd32767) ? 15'h7FFF : t17[14:0];
			B_OUT: begin
				if (res_push) begin
					numx_q <= numx_q + two_dx;
					numy_q <= numy_q + two_dy;
				end
			end
			default: ;
		endcase
	end

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == B_XW || state_q == B_YW))
		else $error("divider finished with no stage waiting for it");

	a_wp_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> (i_q != '0 && i_q <= mv_q.n))
		else $error("waypoint index outside its move");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (servo_q >= 12'd500 && servo_q <= 12'd2500))
		else $error("servo pulse outside 500..2500 us");

	a_last_ends_move: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last_waypoint) |=> (state_q == B_IDLE))
		else $error("final waypoint did not close the move");

endmodule

### test/tb.sv
// Self-checking testbench for the polar line waypoint generator.
`timescale 1ns / 1ps

import plwg_pkg::*;

// Keeps the expected waypoints and a shadow copy of the block's state.
class waypoint_scoreboard;
	localparam int STEPS = 16;
	localparam logic [3:0] COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
	localparam longint ATAN [24] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
		3754631, 1877430, 938729, 469366, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

	logic [11:0]        pivot_x = 160;
	logic [11:0]        pivot_y = 1984;
	logic [11:0]        min_reach = 768;
	logic [12:0]        max_reach = 3200;
	logic signed [14:0] angle_shift = 3072;
	logic [15:0]        steps_q8 = 14486;
	logic [11:0]        seg_len = 80;
	longint             pos_x = -160;
	longint             pos_y = 768 - 1984;
	longint             step_pos = 0;
	logic [1:0]         phase = 0;
	result_t            waypoints_due[$];
	int                 errors = 0;

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PIVOT_X:     pivot_x = data[11:0];
			REG_PIVOT_Y:     pivot_y = data[11:0];
			REG_MIN_REACH:   min_reach = data[11:0];
			REG_MAX_REACH:   max_reach = data[12:0];
			REG_ANGLE_SHIFT: angle_shift = data[14:0];
			REG_STEPS_Q8:    steps_q8 = data;
			REG_SEG_LEN:     seg_len = data[11:0];
			default: ;
		endcase
	endfunction

	function longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function longint root_ceil(longint v);
		longint r;
		r = 0;
		for (int b = 16; b >= 0; b--)
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
				r = r | (64'd1 << b);
		return (r * r < v) ? r + 1 : r;
	endfunction

	// vectoring CORDIC: radius in 1/256 mm, angle in 1/64 degree
	function void to_polar(longint rx, longint ry, output longint rad, output longint ang);
		longint x, y, acc, t, nx, ny;
		x = rx * 256;
		y = ry * 256;
		acc = 0;
		if (rx == 0 && ry == 0) begin
			rad = 0;
			ang = 0;
			return;
		end
		// fold the left half plane over by a quarter turn
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; acc = 90 <<< 22;
			end else begin
				x = -y; y = t; acc = -(90 <<< 22);
			end
		end
		for (int k = 0; k < STEPS; k++) begin
			if (y >= 0) begin
				nx = x + (y >>> k); ny = y - (x >>> k); acc += ATAN[k];
			end else begin
				nx = x - (y >>> k); ny = y + (x >>> k); acc -= ATAN[k];
			end
			x = nx;
			y = ny;
		end
		rad = (x * 39797 + 32768) >>> 16;
		ang = (acc + 32768) >>> 16;
	endfunction

	// Note an accepted target and queue the waypoints it produces.
	function void note_target(longint tx, longint ty);
		longint dx, dy, len, seg, n, span, wx, wy, rad, ang, a, ext, tgt, delta;
		result_t r;
		dx = tx - pos_x;
		dy = ty - pos_y;
		if (dx == 0 && dy == 0)
			return;
		seg = (seg_len == 0) ? 1 : seg_len;
		len = root_ceil(dx * dx + dy * dy);
		n = (len + seg - 1) / seg;
		if (n > 64) n = 64;
		if (n < 1) n = 1;
		span = longint'(max_reach) - longint'(min_reach);
		if (span < 0) span = 0;
		span *= 256;
		for (longint i = 1; i <= n; i++) begin
			wx = pos_x + floor_div(2 * dx * i + n, 2 * n);
			wy = pos_y + floor_div(2 * dy * i + n, 2 * n);
			to_polar(wx + pivot_x, wy + pivot_y, rad, ang);
			a = ang + longint'(angle_shift);
			if (a < 0) a = 0;
			if (a > 17280) a = 17280;
			ext = rad - longint'(min_reach) * 256;
			if (ext < 0) ext = 0;
			if (ext > span) ext = span;
			tgt = (ext * longint'(steps_q8)) >>> 20;
			if (tgt > 32767) tgt = 32767;
			delta = tgt - step_pos;
			step_pos = tgt;
			phase = phase + delta[1:0];
			r.servo_pulse_us = 12'(500 + (a * 2000) / 17280);
			r.stepper_target = 15'(tgt);
			r.step_delta = 16'(delta);
			r.coil_pattern = COILS[phase];
			r.last_waypoint = (i == n);
			waypoints_due.push_back(r);
		end
		pos_x = tx;
		pos_y = ty;
	endfunction

	function void check_waypoint(result_t got);
		result_t want;
		if (waypoints_due.size() == 0) begin
			$error("waypoint with none expected: %p", got);
			errors++;
			return;
		end
		want = waypoints_due.pop_front();
		if (got.servo_pulse_us !== want.servo_pulse_us) begin
			$error("servo_pulse_us: expected %0d, got %0d", want.servo_pulse_us,
				got.servo_pulse_us);
			errors++;
		end
		if (got.stepper_target !== want.stepper_target) begin
			$error("stepper_target: expected %0d, got %0d", want.stepper_target,
				got.stepper_target);
			errors++;
		end
		if (got.step_delta !== want.step_delta) begin
			$error("step_delta: expected %0d, got %0d", want.step_delta, got.step_delta);
			errors++;
		end
		if (got.coil_pattern !== want.coil_pattern) begin
			$error("coil_pattern: expected %h, got %h", want.coil_pattern, got.coil_pattern);
			errors++;
		end
		if (got.last_waypoint !== want.last_waypoint) begin
			$error("last_waypoint: expected %0d, got %0d", want.last_waypoint,
				got.last_waypoint);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	// settle time after the last waypoint: front end of a full move plus slack
	localparam int SETTLE = 400;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  wr_en = 0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  push = 0;
	logic                  full;
	logic signed [12:0]    target_x = '0;
	logic signed [12:0]    target_y = '0;
	logic                  empty;
	logic                  pop = 0;
	logic [11:0]           servo_pulse_us;
	logic [14:0]           stepper_target;
	logic signed [15:0]    step_delta;
	logic [3:0]            coil_pattern;
	logic                  last_waypoint;

	waypoint_scoreboard sb = new();
	int  pop_hold = 0;
	bit  steady = 0;   // when set, neither side idles

	polar_line_waypoint_generator dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#200ms;
		$display("Simulation FAILED");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// waypoint side: drive pop at the falling edge, check each transfer at the rising edge
	always @(negedge clk) begin
		pop <= (pop_hold == 0);
		if (pop_hold > 0) pop_hold <= pop_hold - 1;
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && pop && !empty) begin
			got.servo_pulse_us = servo_pulse_us;
			got.stepper_target = stepper_target;
			got.step_delta = step_delta;
			got.coil_pattern = coil_pattern;
			got.last_waypoint = last_waypoint;
			sb.check_waypoint(got);
			pop_hold <= pick_gap();
		end
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic write_all(int px, int py, int mn, int mx, int sh, int st, int sg);
		write_cfg(REG_PIVOT_X, 16'(px));
		write_cfg(REG_PIVOT_Y, 16'(py));
		write_cfg(REG_MIN_REACH, 16'(mn));
		write_cfg(REG_MAX_REACH, 16'(mx));
		write_cfg(REG_ANGLE_SHIFT, 16'(sh) & 16'h7FFF);
		write_cfg(REG_STEPS_Q8, 16'(st));
		write_cfg(REG_SEG_LEN, 16'(sg));
		write_cfg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		@(negedge clk);
		wr_en <= 0;
	endtask

	// hold push until the transfer, then idle for a random gap if it is not zero
	task automatic send_target(int x, int y);
		int gap;
		@(negedge clk);
		push <= 1;
		target_x <= 13'(x);
		target_y <= 13'(y);
		do @(posedge clk); while (full);
		sb.note_target(x, y);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop push and wait until every waypoint has gone out and the block is quiet
	task automatic drain();
		@(negedge clk);
		push <= 0;
		while (sb.waypoints_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int clamp13(longint v);
		if (v > 4095) return 4095;
		if (v < -4096) return -4096;
		return int'(v);
	endfunction

	// mostly short moves around the current point, some anywhere, some to the same point
	task automatic random_moves(int count);
		int r, reach, x, y;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			reach = (sb.seg_len == 0 ? 1 : sb.seg_len) * 4;
			if (reach > 4095) reach = 4095;
			if (r < 8) begin
				x = int'(sb.pos_x);
				y = int'(sb.pos_y);
			end else if (r < 25) begin
				x = $urandom_range(0, 8191) - 4096;
				y = $urandom_range(0, 8191) - 4096;
			end else begin
				x = clamp13(sb.pos_x + $urandom_range(0, 2 * reach) - reach);
				y = clamp13(sb.pos_y + $urandom_range(0, 2 * reach) - reach);
			end
			send_target(x, y);
			// now and then pause once mid-stream until every waypoint is out
			if (i == count / 2 && r < 30) drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: reset settings, home, corners, the pivot itself
		steady = 1;
		send_target(-160, 768 - 1984);   // already there: no waypoint
		send_target(-160, -1984);        // on the pivot
		send_target(-160, -1984);
		send_target(4095, 4095);
		send_target(-4096, -4096);
		send_target(-4096, 4095);
		send_target(4095, -4096);
		send_target(-2000, 0);           // left of the pivot
		send_target(0, 0);
		send_target(3, -2);
		drain();
		steady = 0;

		// everything at the top
		write_all(4095, 4095, 4095, 8191, 11520, 65535, 4095);
		send_target(4095, 4095);
		send_target(-4096, -4096);
		random_moves(35);
		drain();

		// everything at the bottom: zero segment length counts as one
		write_all(0, 0, 0, 0, -11520, 0, 0);
		send_target(0, 0);
		send_target(1, 0);
		send_target(-1, -1);
		random_moves(30);
		drain();

		// reach limits crossed over
		write_all(2048, 1000, 3000, 100, 0, 1, 200);
		random_moves(30);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			steady = (ph == 2);
			write_all($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 8191),
				$urandom_range(0, 23040) - 11520, $urandom_range(0, 65535),
				$urandom_range(16, 4095));
			random_moves(33);
			drain();
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

### filelist.f
sv/plwg_pkg.sv
sv/plwg_fifo.sv
sv/plwg_div.sv
sv/plwg_front.sv
sv/plwg_back.sv
sv/polar_line_waypoint_generator.sv
test/tb.sv
